// ===== rtl/iac_pkg.sv =====
package iac_pkg;

   localparam int CFG_W      = 7;
   localparam int ADDR_W     = 7;
   localparam int TIME_W     = 6;
   localparam int LAG_W      = 6;
   localparam int PROD_W     = 33;
   localparam int IDX_W      = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int RSP_DATA_W = ((LAG_W + 2 * PROD_W + 7) / 8) * 8;

   localparam logic [CFG_W-1:0] NUM_SAMPLES_RESET = 7'd64;
   localparam logic [CFG_W-1:0] WINDOW_LEN_RESET  = 7'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_SAMPLES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN  = 1'd1;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_SLICE = 1'b1;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_SLICE,
      CMD_ERROR
   } cmd_kind_type;

   typedef enum logic [1:0] {
      LAG_DIRECT,
      LAG_CONJ,
      LAG_ZERO
   } lag_mode_type;

   typedef enum logic {
      ST_IDLE,
      ST_SLICE
   } back_state_type;

   typedef struct packed {
      logic [CFG_W-1:0] num_samples;
      logic [CFG_W-1:0] window_len;
   } cfg_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [ADDR_W-1:0] addr;
      logic [TIME_W-1:0] tidx;
   } cmd_ctl_type;

   typedef struct packed {
      logic [LAG_W-1:0] lag;
      lag_mode_type     mode;
      logic             is_last;
      logic             err;
   } lag_meta_type;

   typedef struct packed {
      logic [LAG_W-1:0]         lag;
      logic signed [PROD_W-1:0] prod_re;
      logic signed [PROD_W-1:0] prod_im;
      logic                     is_last;
      logic                     err;
   } rsp_type;

endpackage

// ===== rtl/instantaneous_autocorrelation_slice.sv =====
// Instantaneous autocorrelation slice: a request with tuser low loads one complex
// sample into the 2*MAX_SIGNAL entry store; a request with tuser high asks for time
// slice t and returns window_len lag products z[t+j-1] * conj(z[t-j-1]) (ring of
// 2*L entries for the configured signal length L, one-based), mirrored as conjugates
// into the upper lags, zero elsewhere, with tlast on the final lag. An invalid time,
// window or signal length gives one result with tuser (error) and tlast set.
// Requests pass through a two-entry command queue to an execution unit with one
// complex multiplier and a two-read-port sample memory: a load is written when the
// unit takes it, a slice issues its lags while the result queue has room, results
// leave at one per cycle while rsp_tready is high, and each lag passes the read
// registers, the product registers and the result queue before it is presented.
module instantaneous_autocorrelation_slice import iac_pkg::*; #(
   parameter int MAX_WINDOW   = 64,
   parameter int MAX_SIGNAL   = 64,
   parameter int SAMPLE_WIDTH = 16,
   localparam int REQ_DATA_W  = ((ADDR_W + 2 * SAMPLE_WIDTH + TIME_W + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // sample_addr, sample_re, sample_im, time_index (from bit 0 up)
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // lag_index, prod_re, prod_im (from bit 0 up)
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // error
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_data
);

   localparam int SW     = SAMPLE_WIDTH;
   localparam int CMD_W  = $bits(cmd_ctl_type) + 2 * SW;
   localparam int CMD_DEPTH = 2;
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   cfg_type         cfg;
   logic            fr_valid, fr_ready;
   cmd_ctl_type     fr_ctl, bk_ctl;
   logic [2*SW-1:0] fr_sample, bk_sample;
   logic [CMD_W-1:0] q_out;
   logic [CMD_CNT_W-1:0] cmd_count;
   logic            bk_valid, bk_ready;
   rsp_type         rsp;

   iac_front #(
      .MAX_WINDOW   (MAX_WINDOW),
      .MAX_SIGNAL   (MAX_SIGNAL),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cfg        (cfg),
      .cmd_valid  (fr_valid),
      .cmd_ready  (fr_ready),
      .cmd_ctl    (fr_ctl),
      .cmd_sample (fr_sample)
   );

   iac_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   ({fr_sample, fr_ctl}),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_data  (q_out),
      .count     (cmd_count)
   );

   assign bk_ctl    = q_out[$bits(cmd_ctl_type)-1:0];
   assign bk_sample = q_out[CMD_W-1:$bits(cmd_ctl_type)];

   iac_back #(
      .MAX_SIGNAL   (MAX_SIGNAL),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd_valid  (bk_valid),
      .cmd_ready  (bk_ready),
      .cmd_ctl    (bk_ctl),
      .cmd_sample (bk_sample),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = RSP_DATA_W'({rsp.prod_im, rsp.prod_re, rsp.lag});
   assign rsp_tuser = rsp.err;
   assign rsp_tlast = rsp.is_last;

   a_cmd_bound: assert property (@(posedge clock) disable iff (reset)
      cmd_count <= CMD_CNT_W'(CMD_DEPTH))
      else $error("command queue count above depth");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) &&
                                       $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("result changed while stalled");

   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("error result without tlast");

endmodule

// ===== rtl/iac_fifo.sv =====
module iac_fifo import iac_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data,
   output logic [CNT_W-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff < CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fifo count above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("fifo count did not grow on push");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("fifo count did not shrink on pop");

endmodule

// ===== rtl/iac_front.sv =====
module iac_front import iac_pkg::*; #(
   parameter int MAX_WINDOW   = 64,
   parameter int MAX_SIGNAL   = 64,
   parameter int SAMPLE_WIDTH = 16,
   localparam int REQ_DATA_W  = ((ADDR_W + 2 * SAMPLE_WIDTH + TIME_W + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_W-1:0]     req_tdata,
   input  logic                      req_tuser,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CFG_W-1:0]          csr_data,
   output cfg_type                   cfg,
   output logic                      cmd_valid,
   input  logic                      cmd_ready,
   output cmd_ctl_type               cmd_ctl,
   output logic [2*SAMPLE_WIDTH-1:0] cmd_sample
);

   localparam int SW          = SAMPLE_WIDTH;
   localparam int STORE_DEPTH = 2 * MAX_SIGNAL;

   logic [CFG_W-1:0]  num_samples_ff, num_samples_in;
   logic [CFG_W-1:0]  window_len_ff, window_len_in;
   logic [ADDR_W-1:0] addr;
   logic [SW-1:0]     sample_re, sample_im;
   logic [TIME_W-1:0] tidx;
   logic [IDX_W-1:0]  len_x, win_x, thr_x, addr_x;
   logic              bad_slice, load_ok;

   assign csr_ready = 1'b1;

   always_comb begin
      num_samples_in = num_samples_ff;
      window_len_in  = window_len_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_SAMPLES: num_samples_in = csr_data;
            CSR_WINDOW_LEN:  window_len_in  = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_samples_ff <= NUM_SAMPLES_RESET;
         window_len_ff  <= WINDOW_LEN_RESET;
      end else begin
         num_samples_ff <= num_samples_in;
         window_len_ff  <= window_len_in;
      end
   end

   assign cfg.num_samples = num_samples_ff;
   assign cfg.window_len  = window_len_ff;

   assign addr      = req_tdata[ADDR_W-1:0];
   assign sample_re = req_tdata[ADDR_W +: SW];
   assign sample_im = req_tdata[ADDR_W + SW +: SW];
   assign tidx      = req_tdata[ADDR_W + 2 * SW +: TIME_W];

   // shortest window that holds both wings: L for odd L, L-1 for even L
   assign len_x  = IDX_W'(num_samples_ff);
   assign win_x  = IDX_W'(window_len_ff);
   assign thr_x  = num_samples_ff[0] ? len_x : len_x - 1'b1;
   assign addr_x = IDX_W'(addr);

   assign bad_slice = (len_x == '0) || (len_x > IDX_W'(MAX_SIGNAL)) ||
                      (win_x > IDX_W'(MAX_WINDOW)) || (win_x < thr_x) ||
                      (IDX_W'(tidx) >= len_x);
   assign load_ok   = (addr_x < IDX_W'(STORE_DEPTH));

   always_comb begin
      cmd_ctl.addr = addr;
      cmd_ctl.tidx = tidx;
      cmd_sample   = {sample_im, sample_re};
      if (req_tuser == REQ_LOAD) begin
         cmd_ctl.kind = CMD_LOAD;
         // drop loads beyond the store
         cmd_valid    = req_tvalid && load_ok;
      end else begin
         cmd_ctl.kind = bad_slice ? CMD_ERROR : CMD_SLICE;
         cmd_valid    = req_tvalid;
      end
   end

   assign req_tready = cmd_ready;

endmodule

// ===== rtl/iac_back.sv =====
module iac_back import iac_pkg::*; #(
   parameter int MAX_SIGNAL   = 64,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      cmd_valid,
   output logic                      cmd_ready,
   input  cmd_ctl_type               cmd_ctl,
   input  logic [2*SAMPLE_WIDTH-1:0] cmd_sample,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp
);

   localparam int SW          = SAMPLE_WIDTH;
   localparam int MW          = 2 * SW;
   localparam int SUM_W       = MW + 1;
   localparam int STORE_DEPTH = 2 * MAX_SIGNAL;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam int OUT_DEPTH   = 4;
   localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

   back_state_type state_ff, state_in;
   logic [CFG_W-1:0]  k_ff, k_in;
   logic [TIME_W-1:0] t_ff, t_in;

   logic [2*SW-1:0] store_ff [STORE_DEPTH];
   logic [2*SW-1:0] rd_a_ff, rd_b_ff;

   logic         s1_valid_ff, s2_valid_ff;
   lag_meta_type s1_meta_ff, s2_meta_ff, iss_meta;
   logic signed [MW-1:0] p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff;

   logic [IDX_W-1:0] len_x, win_x, half_x, n_x, k_x, t_x, j_x, tj_x, a_x, b_x;
   logic [AW-1:0]    rd_a_addr, rd_b_addr;
   lag_mode_type     mode;
   logic             issue, mem_we, credit_ok;
   logic [OCNT_W:0]  occupancy;
   logic [OCNT_W-1:0] out_count;
   logic             out_in_ready;

   logic signed [SW-1:0]     ar, ai, br, bi;
   logic signed [SUM_W-1:0]  re_sum, im_sum;
   logic signed [PROD_W-1:0] re_p, im_p;
   rsp_type                  rsp_push;

   // lag geometry
   assign len_x  = IDX_W'(cfg.num_samples);
   assign win_x  = IDX_W'(cfg.window_len);
   assign half_x = (len_x + 1'b1) >> 1;
   assign n_x    = len_x << 1;
   assign k_x    = IDX_W'(k_ff);
   assign t_x    = IDX_W'(t_ff);

   always_comb begin
      priority if (k_x < half_x) begin
         mode = LAG_DIRECT;
         j_x  = k_x;
      end else if ((win_x - k_x) < half_x) begin
         mode = LAG_CONJ;
         j_x  = win_x - k_x;
      end else begin
         mode = LAG_ZERO;
         j_x  = '0;
      end
   end

   // one-based shift: time zero reads the top entry of the ring
   assign tj_x      = t_x + j_x;
   assign a_x       = (tj_x == '0) ? n_x - 1'b1 : tj_x - 1'b1;
   assign b_x       = (t_x > j_x) ? t_x - j_x - 1'b1 : t_x + n_x - j_x - 1'b1;
   assign rd_a_addr = AW'(a_x);
   assign rd_b_addr = AW'(b_x);

   // issue only when the result queue has room for everything in flight
   assign occupancy = (OCNT_W + 1)'(out_count) + (OCNT_W + 1)'(s1_valid_ff)
                      + (OCNT_W + 1)'(s2_valid_ff);
   assign credit_ok = (occupancy < (OCNT_W + 1)'(OUT_DEPTH));

   always_comb begin
      state_in          = state_ff;
      k_in              = k_ff;
      t_in              = t_ff;
      cmd_ready         = 1'b0;
      issue             = 1'b0;
      mem_we            = 1'b0;
      iss_meta.lag      = k_ff[LAG_W-1:0];
      iss_meta.mode     = mode;
      iss_meta.is_last  = (k_ff == cfg.window_len - 1'b1);
      iss_meta.err      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd_ctl.kind)
                  CMD_LOAD: begin
                     mem_we    = 1'b1;
                     cmd_ready = 1'b1;
                  end
                  CMD_SLICE: begin
                     t_in      = cmd_ctl.tidx;
                     k_in      = '0;
                     state_in  = ST_SLICE;
                     cmd_ready = 1'b1;
                  end
                  CMD_ERROR: begin
                     if (credit_ok) begin
                        issue            = 1'b1;
                        iss_meta.lag     = '0;
                        iss_meta.mode    = LAG_ZERO;
                        iss_meta.is_last = 1'b1;
                        iss_meta.err     = 1'b1;
                        cmd_ready        = 1'b1;
                     end
                  end
                  default: begin
                     cmd_ready = 1'b1;
                  end
               endcase
            end
         end
         ST_SLICE: begin
            if (credit_ok) begin
               issue = 1'b1;
               if (iss_meta.is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         k_ff        <= '0;
         t_ff        <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         k_ff        <= k_in;
         t_ff        <= t_in;
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // sample store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[AW'(cmd_ctl.addr)] <= cmd_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_a_ff <= store_ff[rd_a_addr];
         rd_b_ff <= store_ff[rd_b_addr];
      end
   end

   always_ff @(posedge clock) begin
      s1_meta_ff <= iss_meta;
      s2_meta_ff <= s1_meta_ff;
   end

   assign ar = rd_a_ff[SW-1:0];
   assign ai = rd_a_ff[2*SW-1:SW];
   assign br = rd_b_ff[SW-1:0];
   assign bi = rd_b_ff[2*SW-1:SW];

   always_ff @(posedge clock) begin
      p_rr_ff <= ar * br;
      p_ii_ff <= ai * bi;
      p_ir_ff <= ai * br;
      p_ri_ff <= ar * bi;
   end

   // z[a] * conj(z[b]); wider samples wrap to the output width
   assign re_sum = SUM_W'(p_rr_ff) + SUM_W'(p_ii_ff);
   assign im_sum = SUM_W'(p_ir_ff) - SUM_W'(p_ri_ff);
   assign re_p   = PROD_W'(re_sum);
   assign im_p   = PROD_W'(im_sum);

   always_comb begin
      rsp_push.lag     = s2_meta_ff.lag;
      rsp_push.is_last = s2_meta_ff.is_last;
      rsp_push.err     = s2_meta_ff.err;
      unique case (s2_meta_ff.mode)
         LAG_DIRECT: begin
            rsp_push.prod_re = re_p;
            rsp_push.prod_im = im_p;
         end
         LAG_CONJ: begin
            rsp_push.prod_re = re_p;
            rsp_push.prod_im = -im_p;
         end
         default: begin
            rsp_push.prod_re = '0;
            rsp_push.prod_im = '0;
         end
      endcase
   end

   iac_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_ready  (out_in_ready),
      .in_data   (rsp_push),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp),
      .count     (out_count)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> out_in_ready)
      else $error("result pushed into a full queue");

   a_lag_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SLICE) |-> (k_ff < cfg.window_len))
      else $error("lag counter beyond window");

   a_last_ends_slice: assert property (@(posedge clock) disable iff (reset)
      (issue && (state_ff == ST_SLICE) && iss_meta.is_last) |=> (state_ff == ST_IDLE))
      else $error("slice did not end after its final lag");

endmodule
